// ===== rtl/uvcfa_pkg.sv =====
// Shared types, constants and helpers for the UVC payload frame assembler.
// No dependencies; imported by every module of the block.
`default_nettype none

package uvcfa_pkg;

    // Defaults for the top-level parameters
    localparam int unsigned FRAME_CAPACITY_DEF = 8388608;
    localparam int unsigned PACKET_MAX_DEF     = 1048576;

    // Reset value of the frame limit register
    localparam logic [23:0] FRAME_LIMIT_RESET = 24'h800000;

    // Bit positions in the header flags byte
    localparam int unsigned FLAG_ID_BIT    = 0;
    localparam int unsigned FLAG_EOF_BIT   = 1;
    localparam int unsigned FLAG_ERROR_BIT = 6;

    // Result kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_DESC  = 1'b1;

    // Result queue depth
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QW     = $clog2(QDEPTH);
    localparam int unsigned QCW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic        kind;
        logic [22:0] addr;
        logic [7:0]  data;
        logic [23:0] flen;
        logic [31:0] seq;
        logic        last;
    } t_result;

    // Results produced by one input beat, packed from slot 0
    typedef struct packed {
        logic [1:0]        num;
        t_result [1:0]     res;
    } t_push;

    function automatic t_result make_write(input logic [23:0] fill, input logic [7:0] data);
        t_result r;
        r      = '0;
        r.kind = KIND_WRITE;
        r.addr = fill[22:0];
        r.data = data;
        return r;
    endfunction

    function automatic t_result make_desc(input logic [23:0] flen, input logic [31:0] seq);
        t_result r;
        r      = '0;
        r.kind = KIND_DESC;
        r.flen = flen;
        r.seq  = seq;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/uvcfa_parser.sv =====
// Packet parser and frame bookkeeping: one input beat per cycle, up to two results.
// Depends on uvcfa_pkg.
`default_nettype none

module uvcfa_parser #(
    parameter int unsigned FRAME_CAPACITY = uvcfa_pkg::FRAME_CAPACITY_DEF,
    parameter int unsigned PACKET_MAX     = uvcfa_pkg::PACKET_MAX_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic [7:0]           i_data_byte,
    input  wire logic                 i_packet_start,
    input  wire logic [20:0]          i_packet_length,
    input  wire logic [23:0]          i_frame_limit,
    output uvcfa_pkg::t_push          o_push
);
    import uvcfa_pkg::*;

    localparam logic [24:0] CAP  = 25'(FRAME_CAPACITY);
    localparam logic [21:0] PMAX = 22'(PACKET_MAX);

    logic [20:0] r_pos,      n_pos;
    logic [20:0] r_len,      n_len;
    logic [7:0]  r_hdr,      n_hdr;
    logic        r_skip,     n_skip;
    logic        r_eof,      n_eof;
    logic        r_id_known, n_id_known;
    logic        r_id,       n_id;
    logic [23:0] r_fill,     n_fill;
    logic [31:0] r_count,    n_count;

    logic [23:0] fill_a;
    logic [31:0] count_a;
    logic        eof_a;
    logic        go_end;
    logic [21:0] pos_inc;
    logic [24:0] limit;
    logic [20:0] payload;
    logic        fid;
    t_result     res_a, res_b;
    logic        a_v, b_v;

    always_comb begin
        n_pos      = r_pos;
        n_len      = r_len;
        n_hdr      = r_hdr;
        n_skip     = r_skip;
        n_eof      = r_eof;
        n_id_known = r_id_known;
        n_id       = r_id;
        n_fill     = r_fill;
        n_count    = r_count;
        fill_a     = r_fill;
        count_a    = r_count;
        eof_a      = r_eof;
        go_end     = 1'b0;
        res_a      = '0;
        res_b      = '0;
        a_v        = 1'b0;
        b_v        = 1'b0;
        pos_inc    = {1'b0, r_pos} + 22'd1;
        limit      = ({1'b0, i_frame_limit} < CAP) ? {1'b0, i_frame_limit} : CAP;
        payload    = r_len - 21'(r_hdr);
        fid        = i_data_byte[FLAG_ID_BIT];

        if (i_accept) begin
            if (i_packet_start) begin
                n_len  = i_packet_length;
                n_hdr  = i_data_byte;
                n_pos  = 21'd1;
                n_eof  = 1'b0;
                n_skip = (i_packet_length < 21'd2) || ({1'b0, i_packet_length} > PMAX)
                      || (i_data_byte < 8'd2) || (21'(i_data_byte) > i_packet_length);
            end else if (!r_skip) begin
                if (r_pos == 21'd1) begin
                    // flags byte
                    if (i_data_byte[FLAG_ERROR_BIT]) begin
                        n_fill     = '0;
                        n_id_known = 1'b0;
                        n_skip     = 1'b1;
                    end else begin
                        eof_a      = i_data_byte[FLAG_EOF_BIT];
                        n_eof      = eof_a;
                        n_id       = fid;
                        n_id_known = 1'b1;
                        if (r_id_known && (fid != r_id)) begin
                            if (r_fill != '0) begin
                                a_v     = 1'b1;
                                res_a   = make_desc(r_fill, r_count);
                                count_a = r_count + 32'd1;
                            end
                            fill_a = '0;
                        end
                        if ((payload != '0) && (({1'b0, fill_a} + 25'(payload)) > limit)) begin
                            n_fill     = '0;
                            n_count    = count_a;
                            n_id_known = 1'b0;
                            n_skip     = 1'b1;
                        end else begin
                            go_end = 1'b1;
                        end
                    end
                end else begin
                    if (21'(r_hdr) <= r_pos) begin
                        a_v    = 1'b1;
                        res_a  = make_write(r_fill, i_data_byte);
                        fill_a = r_fill + 24'd1;
                    end
                    go_end = 1'b1;
                end

                if (go_end) begin
                    n_fill  = fill_a;
                    n_count = count_a;
                    n_pos   = pos_inc[20:0];
                    if (pos_inc >= {1'b0, r_len}) begin
                        if (eof_a) begin
                            if (fill_a != '0) begin
                                b_v     = 1'b1;
                                res_b   = make_desc(fill_a, count_a);
                                n_count = count_a + 32'd1;
                            end
                            n_fill     = '0;
                            n_id_known = 1'b0;
                        end
                        n_skip = 1'b1;
                    end
                end
            end
        end

        if (b_v) begin
            res_b.last = 1'b1;
        end else begin
            res_a.last = a_v;
        end
        o_push.num    = 2'(a_v) + 2'(b_v);
        o_push.res[0] = a_v ? res_a : res_b;
        o_push.res[1] = res_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_len      <= '0;
            r_hdr      <= '0;
            r_skip     <= 1'b1;
            r_eof      <= 1'b0;
            r_id_known <= 1'b0;
            r_id       <= 1'b0;
            r_fill     <= '0;
            r_count    <= '0;
        end else begin
            r_pos      <= n_pos;
            r_len      <= n_len;
            r_hdr      <= n_hdr;
            r_skip     <= n_skip;
            r_eof      <= n_eof;
            r_id_known <= n_id_known;
            r_id       <= n_id;
            r_fill     <= n_fill;
            r_count    <= n_count;
        end
    end

    // A closed frame always leaves the fill empty behind it
    a_desc_clears_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_v) |=> (r_fill == '0))
        else $error("fill not cleared after end-of-frame descriptor");

    // A descriptor closed on a frame-id change bumps the sequence by exactly one
    a_seq_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_packet_start && !r_skip && (r_pos == 21'd1) && a_v && !b_v)
        |=> (r_count == $past(r_count) + 32'd1))
        else $error("sequence did not advance on frame-id close");

endmodule

`default_nettype wire

// ===== rtl/uvcfa_result_queue.sv =====
// Small register queue of result beats; takes up to two per cycle, gives one while i_ready.
// Depends on uvcfa_pkg.
`default_nettype none

module uvcfa_result_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire uvcfa_pkg::t_push     i_push,
    output logic                      o_room,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output uvcfa_pkg::t_result        o_head
);
    import uvcfa_pkg::*;

    t_result           r_ent [QDEPTH];
    logic [QW-1:0]     r_wr, n_wr;
    logic [QW-1:0]     r_rd, n_rd;
    logic [QCW-1:0]    r_count, n_count;
    logic              pop;
    logic [QW-1:0]     wr_next;

    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= QCW'(QDEPTH - 2));
    assign o_head  = r_ent[r_rd];
    assign pop     = o_valid && i_ready;
    assign wr_next = r_wr + QW'(1);

    always_comb begin
        n_wr    = r_wr + QW'(i_push.num);
        n_rd    = r_rd + QW'(pop);
        n_count = r_count + QCW'(i_push.num) - QCW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_ent[r_wr] <= i_push.res[0];
        end
        if (i_push.num == 2'd2) begin
            r_ent[wr_next] <= i_push.res[1];
        end
    end

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCW'(QDEPTH))
        else $error("result queue overfilled");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.num != 2'd0) |-> $past(o_room) || (r_count <= QCW'(QDEPTH - 2)))
        else $error("push without room");

    a_desc_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_head.kind == KIND_DESC)) |-> (o_head.flen != '0))
        else $error("empty frame descriptor");

endmodule

`default_nettype wire

// ===== rtl/uvc_payload_frame_assembler.sv =====
// Top level of the UVC payload frame assembler: parser plus result queue.
// Depends on uvcfa_pkg, uvcfa_parser, uvcfa_result_queue.
//
// Usage:
//  - Input channel (i_in_valid / o_in_ready): one packet byte per beat with its
//    packet_start flag and packet length. Header bytes are parsed; payload bytes
//    become frame-memory writes.
//  - Output channel (o_out_valid / i_out_ready): one result per beat. Kind 0 is a
//    payload byte write (address, data); kind 1 is a completed-frame descriptor
//    (length, sequence). o_last_result marks the last result of an input byte.
//  - Config channel (i_cfg_valid / o_cfg_ready): writes the 24-bit frame limit.
//    Always ready; write only while the block is idle.
//  - A result is registered in the result queue before it reaches the output.
//  - Throughput: one input byte per cycle. A byte gives at most two results
//    (last payload byte plus its frame descriptor); the output drains one per
//    cycle, so the four-entry result queue sets the rate when descriptors bunch.
//  - o_in_ready is high while the queue has room for two results; it comes from
//    a register, with no path from i_out_ready.
//  - Receiver stall: results wait in the queue; input stalls once fewer than
//    two entries are free.
//  - Reset (synchronous, active low): parser ignores bytes until a packet start,
//    no frame in progress, sequence 0, queue empty, frame limit 8388608.
`default_nettype none

module uvc_payload_frame_assembler #(
    parameter int unsigned FRAME_CAPACITY = uvcfa_pkg::FRAME_CAPACITY_DEF,
    parameter int unsigned PACKET_MAX     = uvcfa_pkg::PACKET_MAX_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [23:0] i_cfg_frame_limit,
    // input beats
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_packet_start,
    input  wire logic [20:0] i_packet_length,
    // result beats
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_result_kind,
    output logic [22:0]      o_write_address,
    output logic [7:0]       o_write_data,
    output logic [23:0]      o_frame_length,
    output logic [31:0]      o_frame_sequence,
    output logic             o_last_result
);
    import uvcfa_pkg::*;

    logic [23:0] r_frame_limit;
    logic        accept;
    t_push       push;
    t_result     head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_limit <= FRAME_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_frame_limit <= i_cfg_frame_limit;
        end
    end

    assign accept = i_in_valid && o_in_ready;

    uvcfa_parser #(
        .FRAME_CAPACITY (FRAME_CAPACITY),
        .PACKET_MAX     (PACKET_MAX)
    ) u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_data_byte     (i_data_byte),
        .i_packet_start  (i_packet_start),
        .i_packet_length (i_packet_length),
        .i_frame_limit   (r_frame_limit),
        .o_push          (push)
    );

    uvcfa_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_head  (head)
    );

    // Fields of the head result
    assign o_result_kind    = head.kind;
    assign o_write_address  = head.addr;
    assign o_write_data     = head.data;
    assign o_frame_length   = head.flen;
    assign o_frame_sequence = head.seq;
    assign o_last_result    = head.last;

endmodule

`default_nettype wire
